### sv/fpmw_pkg.sv
// Shared sizes and types for the flash page map writer.
// Used by every module of the block; depends on nothing.
`default_nettype none

package fpmw_pkg;

    // Geometry of the flash array
    localparam int POOLS           = 8;
    localparam int BLOCKS_PER_POOL = 32;
    localparam int PAGES_PER_BLOCK = 64;

    // Derived widths
    localparam int POOL_W      = $clog2(POOLS);
    localparam int BLK_W       = $clog2(BLOCKS_PER_POOL);
    localparam int PG_W        = $clog2(PAGES_PER_BLOCK);
    localparam int CNT_W       = $clog2(PAGES_PER_BLOCK + 1);
    localparam int GBLK_W      = POOL_W + BLK_W;
    localparam int PHYS_W      = GBLK_W + PG_W;
    localparam int TOTAL_BLOCKS = POOLS * BLOCKS_PER_POOL;
    localparam int TOTAL_PAGES = TOTAL_BLOCKS * PAGES_PER_BLOCK;
    localparam int MAP_W       = PHYS_W + 1;

    // Allocation decision for the selected pool
    typedef struct packed {
        logic             no_space;
        logic [BLK_W-1:0] blk;
        logic [PG_W-1:0]  page;
    } t_alloc;

endpackage

`default_nettype wire

### sv/fpmw_sat_inc.sv
// Shared saturating incrementer, limit is the page count of a block.
// Depends on fpmw_pkg for the counter width and the limit.
`default_nettype none

module fpmw_sat_inc (
    input  wire logic [fpmw_pkg::CNT_W-1:0] i_operand,
    output logic      [fpmw_pkg::CNT_W-1:0] o_result
);

    // Add one, hold at the page count
    always_comb begin
        if (i_operand >= fpmw_pkg::CNT_W'(fpmw_pkg::PAGES_PER_BLOCK)) begin
            o_result = fpmw_pkg::CNT_W'(fpmw_pkg::PAGES_PER_BLOCK);
        end else begin
            o_result = i_operand + fpmw_pkg::CNT_W'(1);
        end
    end

endmodule

`default_nettype wire

### sv/fpmw_pool_alloc.sv
// Per-pool append point: current block and pages used in it.
// Blocks leave each pool's free list in ascending order, so the list head
// always follows the current block. Depends on fpmw_pkg.
`default_nettype none

module fpmw_pool_alloc (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic [fpmw_pkg::POOL_W-1:0] i_pool,
    input  wire logic                        i_commit,
    input  wire logic [fpmw_pkg::CNT_W-1:0]  i_pages_next,
    output fpmw_pkg::t_alloc                 o_alloc,
    output logic      [fpmw_pkg::CNT_W-1:0]  o_pages
);

    logic [fpmw_pkg::BLK_W-1:0] r_cur   [fpmw_pkg::POOLS];
    logic [fpmw_pkg::CNT_W-1:0] r_pages [fpmw_pkg::POOLS];
    logic                       full;
    logic                       last;

    // Decide the page to use: next page of the current block, or the first
    // page of the next free block when the current one is full
    always_comb begin
        full = (r_pages[i_pool] == fpmw_pkg::CNT_W'(fpmw_pkg::PAGES_PER_BLOCK));
        last = (r_cur[i_pool] == fpmw_pkg::BLK_W'(fpmw_pkg::BLOCKS_PER_POOL - 1));
        o_alloc.no_space = full && last;
        if (full) begin
            o_alloc.blk  = r_cur[i_pool] + fpmw_pkg::BLK_W'(1);
            o_alloc.page = '0;
            o_pages      = '0;
        end else begin
            o_alloc.blk  = r_cur[i_pool];
            o_alloc.page = r_pages[i_pool][fpmw_pkg::PG_W-1:0];
            o_pages      = r_pages[i_pool];
        end
    end

    // Advance the append point of the pool on a successful write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < fpmw_pkg::POOLS; p++) begin
                r_cur[p]   <= '0;
                r_pages[p] <= '0;
            end
        end else if (i_commit) begin
            r_cur[i_pool]   <= o_alloc.blk;
            r_pages[i_pool] <= i_pages_next;
        end
    end

endmodule

`default_nettype wire

### sv/flash_page_map_writer.sv
// Flash page map writer: top level with sequencer, map table and block
// invalid counters. Depends on fpmw_pkg, fpmw_pool_alloc, fpmw_sat_inc.
//
//  channel  | ports                                     | handshake
//  ---------+-------------------------------------------+--------------------------
//  write in | i_logical_page                            | start high, busy low
//  result   | o_physical_page, o_no_space,              | o_valid, one cycle, taken
//           | o_append_point, o_replaced,               | at the edge ending it
//           | o_replaced_block, o_replaced_block_invalid|
//
// A word runs through map read, allocate and map write, then the read-modify-write
// of the old block's invalid counter; that last step is skipped when there is no
// space or no old mapping. The result strobe rises as busy falls, and the next
// word may start in that same cycle.
// After reset a clearing pass writes every map entry once and clears every invalid
// counter: busy stays high through the pass over TOTAL_PAGES = 16384 entries.
// The receiver cannot stall; results are never held back.
`default_nettype none

module flash_page_map_writer (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [fpmw_pkg::PHYS_W-1:0]   i_logical_page,
    output logic                               o_valid,
    output logic      [fpmw_pkg::PHYS_W-1:0]   o_physical_page,
    output logic                               o_no_space,
    output logic      [fpmw_pkg::POOL_W-1:0]   o_append_point,
    output logic                               o_replaced,
    output logic      [fpmw_pkg::GBLK_W-1:0]   o_replaced_block,
    output logic      [fpmw_pkg::CNT_W-1:0]    o_replaced_block_invalid
);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_ALLOC = 4'b0100,
        S_INV   = 4'b1000
    } t_state;

    t_state                          r_state;
    logic [fpmw_pkg::PHYS_W-1:0]     r_clr_idx;
    logic [fpmw_pkg::PHYS_W-1:0]     r_logical;
    logic [fpmw_pkg::POOL_W-1:0]     r_rr;
    logic [fpmw_pkg::POOL_W-1:0]     r_pool;
    logic [fpmw_pkg::MAP_W-1:0]      r_map_q;
    logic [fpmw_pkg::CNT_W-1:0]      r_inv_q;
    logic [fpmw_pkg::GBLK_W-1:0]     r_rep_block;
    logic [fpmw_pkg::PHYS_W-1:0]     r_phys;

    logic [fpmw_pkg::MAP_W-1:0]      page_map [fpmw_pkg::TOTAL_PAGES];
    logic [fpmw_pkg::CNT_W-1:0]      inv_mem  [fpmw_pkg::TOTAL_BLOCKS];

    logic                            accept;
    logic [fpmw_pkg::POOL_W-1:0]     pool_next;
    fpmw_pkg::t_alloc                alloc;
    logic [fpmw_pkg::CNT_W-1:0]      alloc_pages;
    logic                            commit;
    logic [fpmw_pkg::CNT_W-1:0]      inc_operand;
    logic [fpmw_pkg::CNT_W-1:0]      inc_result;
    logic [fpmw_pkg::PHYS_W-1:0]     phys_new;
    logic                            map_hit;
    logic [fpmw_pkg::GBLK_W-1:0]     old_block;

    assign busy      = (r_state != S_IDLE);
    assign accept    = start && !busy;
    assign pool_next = r_rr + fpmw_pkg::POOL_W'(1);
    assign commit    = (r_state == S_ALLOC) && !alloc.no_space;
    assign phys_new  = {r_pool, alloc.blk, alloc.page};
    assign map_hit   = r_map_q[fpmw_pkg::PHYS_W];
    assign old_block = r_map_q[fpmw_pkg::PHYS_W-1:fpmw_pkg::PG_W];

    // Steer the shared incrementer: page count while allocating, invalid
    // count while updating the old block
    assign inc_operand = (r_state == S_INV) ? r_inv_q : alloc_pages;

    fpmw_sat_inc u_inc (
        .i_operand (inc_operand),
        .o_result  (inc_result)
    );

    fpmw_pool_alloc u_alloc (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pool       (r_pool),
        .i_commit     (commit),
        .i_pages_next (inc_result),
        .o_alloc      (alloc),
        .o_pages      (alloc_pages)
    );

    // Map table: clear after reset, read on accept, write on allocation
    always_ff @(posedge i_clk) begin
        if (r_state == S_CLEAR) begin
            page_map[r_clr_idx] <= '0;
        end else if (commit) begin
            page_map[r_logical] <= {1'b1, phys_new};
        end
        if (accept) begin
            r_map_q <= page_map[i_logical_page];
        end
    end

    // Block invalid counters: clear after reset, read-modify-write on replace
    always_ff @(posedge i_clk) begin
        if (r_state == S_CLEAR) begin
            inv_mem[r_clr_idx[fpmw_pkg::GBLK_W-1:0]] <= '0;
        end else if (r_state == S_INV) begin
            inv_mem[r_rep_block] <= inc_result;
        end
        if (commit && map_hit) begin
            r_inv_q <= inv_mem[old_block];
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr_idx <= '0;
            r_rr      <= fpmw_pkg::POOL_W'(fpmw_pkg::POOLS - 1);
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_idx <= r_clr_idx + fpmw_pkg::PHYS_W'(1);
                    if (r_clr_idx == fpmw_pkg::PHYS_W'(fpmw_pkg::TOTAL_PAGES - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (start) begin
                        r_rr    <= pool_next;
                        r_state <= S_ALLOC;
                    end
                end
                S_ALLOC: begin
                    if (commit && map_hit) begin
                        r_state <= S_INV;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_INV: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_CLEAR;
                end
            endcase
        end
    end

    // Hold the word and the allocation details across the sequence
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_logical <= i_logical_page;
            r_pool    <= pool_next;
        end
        if (commit) begin
            r_phys      <= phys_new;
            r_rep_block <= old_block;
        end
    end

    // Result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= ((r_state == S_ALLOC) && !(commit && map_hit))
                       || (r_state == S_INV);
        end
    end

    // Result word
    always_ff @(posedge i_clk) begin
        if (r_state == S_ALLOC) begin
            o_append_point <= r_pool;
            o_no_space     <= alloc.no_space;
            if (alloc.no_space) begin
                o_physical_page <= '0;
            end else begin
                o_physical_page <= phys_new;
            end
            o_replaced               <= 1'b0;
            o_replaced_block         <= '0;
            o_replaced_block_invalid <= '0;
        end else if (r_state == S_INV) begin
            o_physical_page          <= r_phys;
            o_replaced               <= 1'b1;
            o_replaced_block         <= r_rep_block;
            o_replaced_block_invalid <= inc_result;
        end
    end

endmodule

`default_nettype wire

### sim/tb_flash_page_map_writer.sv
// Self-checking testbench for flash_page_map_writer: a directed table, random writes and
// rewrites of first-block pages, checked against typed-in results or an in-bench allocator model.
// Depends on fpmw_pkg and flash_page_map_writer.
`timescale 1ns / 1ps

module tb_flash_page_map_writer;

    localparam int CYCLE_LIMIT  = 900000;
    localparam int TAIL_CYCLES  = 8;
    localparam int RANDOM_WORDS = 470;
    localparam int FL_CNT_W     = fpmw_pkg::BLK_W + 1;

    // One result word, in port order
    typedef struct packed {
        logic [fpmw_pkg::PHYS_W-1:0] phys;
        logic                        no_space;
        logic [fpmw_pkg::POOL_W-1:0] pool;
        logic                        replaced;
        logic [fpmw_pkg::GBLK_W-1:0] rep_blk;
        logic [fpmw_pkg::CNT_W-1:0]  rep_inv;
    } t_wr_result;

    // One row of the directed table; known rows carry a typed-in result
    typedef struct packed {
        logic [fpmw_pkg::PHYS_W-1:0] lp;
        logic                        known;
        t_wr_result                  res;
    } t_dir_row;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          start;
    logic                          busy;
    logic [fpmw_pkg::PHYS_W-1:0]   i_logical_page;
    logic                          o_valid;
    logic [fpmw_pkg::PHYS_W-1:0]   o_physical_page;
    logic                          o_no_space;
    logic [fpmw_pkg::POOL_W-1:0]   o_append_point;
    logic                          o_replaced;
    logic [fpmw_pkg::GBLK_W-1:0]   o_replaced_block;
    logic [fpmw_pkg::CNT_W-1:0]    o_replaced_block_invalid;

    // Allocator state mirrored by the testbench
    logic [fpmw_pkg::POOL_W-1:0]   rr_pool;
    logic [fpmw_pkg::BLK_W-1:0]    cur_blk  [fpmw_pkg::POOLS];
    logic [fpmw_pkg::BLK_W-1:0]    fl_head  [fpmw_pkg::POOLS];
    logic [FL_CNT_W-1:0]           fl_cnt   [fpmw_pkg::POOLS];
    logic [fpmw_pkg::BLK_W-1:0]    fl_queue [fpmw_pkg::POOLS][fpmw_pkg::BLOCKS_PER_POOL];
    logic [fpmw_pkg::CNT_W-1:0]    used_pg  [fpmw_pkg::TOTAL_BLOCKS];
    logic [fpmw_pkg::CNT_W-1:0]    inv_pg   [fpmw_pkg::TOTAL_BLOCKS];
    logic [fpmw_pkg::MAP_W-1:0]    map_tbl  [fpmw_pkg::TOTAL_PAGES];

    t_wr_result                    wr_expected [$];
    logic [fpmw_pkg::PHYS_W-1:0]   recent_lp [$];
    int                            mismatch_count = 0;
    int                            cycle_count    = 0;
    bit                            no_gaps        = 1'b0;

    flash_page_map_writer dut (
        .i_clk                    (i_clk),
        .i_rst_n                  (i_rst_n),
        .start                    (start),
        .busy                     (busy),
        .i_logical_page           (i_logical_page),
        .o_valid                  (o_valid),
        .o_physical_page          (o_physical_page),
        .o_no_space               (o_no_space),
        .o_append_point           (o_append_point),
        .o_replaced               (o_replaced),
        .o_replaced_block         (o_replaced_block),
        .o_replaced_block_invalid (o_replaced_block_invalid)
    );

    // Free-running clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Bring the model to its post-reset state
    task automatic reset_alloc_model();
        rr_pool = fpmw_pkg::POOL_W'(fpmw_pkg::POOLS - 1);
        for (int p = 0; p < fpmw_pkg::POOLS; p++) begin
            cur_blk[p] = '0;
            fl_head[p] = fpmw_pkg::BLK_W'(1);
            fl_cnt[p]  = FL_CNT_W'(fpmw_pkg::BLOCKS_PER_POOL - 1);
            for (int b = 0; b < fpmw_pkg::BLOCKS_PER_POOL; b++)
                fl_queue[p][b] = fpmw_pkg::BLK_W'(b);
        end
        for (int b = 0; b < fpmw_pkg::TOTAL_BLOCKS; b++) begin
            used_pg[b] = '0;
            inv_pg[b]  = '0;
        end
        for (int i = 0; i < fpmw_pkg::TOTAL_PAGES; i++)
            map_tbl[i] = '0;
    endtask

    // Allocate a page for one logical write and update the model
    function automatic t_wr_result allocate_page(input logic [fpmw_pkg::PHYS_W-1:0] lp);
        t_wr_result                  r;
        logic [fpmw_pkg::POOL_W-1:0] pool;
        logic [fpmw_pkg::GBLK_W-1:0] gblk;
        logic [fpmw_pkg::PG_W-1:0]   page;
        logic [fpmw_pkg::MAP_W-1:0]  entry;
        pool    = (rr_pool == fpmw_pkg::POOL_W'(fpmw_pkg::POOLS - 1)) ? '0 : rr_pool + 1'b1;
        rr_pool = pool;
        r       = '0;
        r.pool  = pool;
        gblk    = {pool, cur_blk[pool]};
        // Current block full: open the next one from the pool's free list
        if (used_pg[gblk] >= fpmw_pkg::CNT_W'(fpmw_pkg::PAGES_PER_BLOCK)) begin
            if (fl_cnt[pool] == '0) begin
                r.no_space = 1'b1;
                return r;
            end
            cur_blk[pool] = fl_queue[pool][fl_head[pool]];
            fl_head[pool] = fl_head[pool] + 1'b1;
            fl_cnt[pool]  = fl_cnt[pool] - 1'b1;
            gblk          = {pool, cur_blk[pool]};
            if (used_pg[gblk] >= fpmw_pkg::CNT_W'(fpmw_pkg::PAGES_PER_BLOCK)) begin
                r.no_space = 1'b1;
                return r;
            end
        end
        page          = used_pg[gblk][fpmw_pkg::PG_W-1:0];
        used_pg[gblk] = used_pg[gblk] + 1'b1;
        r.phys        = {gblk, page};
        // Invalidate any earlier mapping of this logical page
        entry = map_tbl[lp];
        if (entry[fpmw_pkg::MAP_W-1]) begin
            r.replaced = 1'b1;
            r.rep_blk  = entry[fpmw_pkg::PHYS_W-1:fpmw_pkg::PG_W];
            if (inv_pg[r.rep_blk] < fpmw_pkg::CNT_W'(fpmw_pkg::PAGES_PER_BLOCK))
                inv_pg[r.rep_blk] = inv_pg[r.rep_blk] + 1'b1;
            r.rep_inv  = inv_pg[r.rep_blk];
        end
        map_tbl[lp] = {1'b1, r.phys};
        return r;
    endfunction

    function automatic t_dir_row dir_row(input int lp, input bit known, input int phys,
                                         input int pool, input bit rep, input int blk,
                                         input int inv);
        t_dir_row d;
        d.lp           = fpmw_pkg::PHYS_W'(lp);
        d.known        = known;
        d.res.phys     = fpmw_pkg::PHYS_W'(phys);
        d.res.no_space = 1'b0;
        d.res.pool     = fpmw_pkg::POOL_W'(pool);
        d.res.replaced = rep;
        d.res.rep_blk  = fpmw_pkg::GBLK_W'(blk);
        d.res.rep_inv  = fpmw_pkg::CNT_W'(inv);
        return d;
    endfunction

    // Pick a logical page: often one written lately, sometimes an extreme
    function automatic logic [fpmw_pkg::PHYS_W-1:0] pick_page();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 4 && recent_lp.size() > 0)
            return recent_lp[$urandom_range(0, recent_lp.size() - 1)];
        if (sel == 4)
            return ($urandom_range(0, 1) == 1) ?
                   fpmw_pkg::PHYS_W'(fpmw_pkg::TOTAL_PAGES - 1) : '0;
        return fpmw_pkg::PHYS_W'($urandom_range(0, fpmw_pkg::TOTAL_PAGES - 1));
    endfunction

    // Offer one write word, wait for it to be taken, then log its result
    task automatic push_write(input logic [fpmw_pkg::PHYS_W-1:0] lp, input bit known,
                              input t_wr_result typed);
        t_wr_result r;
        while (!no_gaps && $urandom_range(0, 99) < 22) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start          <= 1'b1;
        i_logical_page <= lp;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        r = allocate_page(lp);
        wr_expected.push_back(known ? typed : r);
        recent_lp.push_back(lp);
        if (recent_lp.size() > 32)
            void'(recent_lp.pop_front());
    endtask

    // Hold off until every outstanding result word has come back
    task automatic drain_results();
        start <= 1'b0;
        while (wr_expected.size() != 0) @(posedge i_clk);
    endtask

    function automatic void log_mismatch(input string what, input t_wr_result want,
                                         input t_wr_result got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("%s at %0t", what, $realtime);
            $display("  expected phys=%0d nosp=%0b ap=%0d rep=%0b blk=%0d inv=%0d",
                     want.phys, want.no_space, want.pool, want.replaced,
                     want.rep_blk, want.rep_inv);
            $display("  got      phys=%0d nosp=%0b ap=%0d rep=%0b blk=%0d inv=%0d",
                     got.phys, got.no_space, got.pool, got.replaced,
                     got.rep_blk, got.rep_inv);
        end
    endfunction

    // Compare each result word with the oldest expected one
    always @(posedge i_clk) begin : result_check
        t_wr_result got;
        t_wr_result want;
        if (i_rst_n && o_valid) begin
            got = {o_physical_page, o_no_space, o_append_point, o_replaced,
                   o_replaced_block, o_replaced_block_invalid};
            if (wr_expected.size() == 0) begin
                log_mismatch("unexpected result", '0, got);
            end else begin
                want = wr_expected.pop_front();
                if (got !== want)
                    log_mismatch("result mismatch", want, got);
            end
        end
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        t_dir_row                    dir_tab [$];
        logic [fpmw_pkg::PHYS_W-1:0] stale_lps [$];
        start          = 1'b0;
        i_logical_page = '0;
        i_rst_n        = 1'b0;

        // Extremes and early replacements are typed in; the rest go to the model
        dir_tab.push_back(dir_row(0,      1, 0,     0, 0, 0,   0));
        dir_tab.push_back(dir_row(16383,  1, 2048,  1, 0, 0,   0));
        dir_tab.push_back(dir_row(0,      1, 4096,  2, 1, 0,   1));
        dir_tab.push_back(dir_row(16383,  1, 6144,  3, 1, 32,  1));
        dir_tab.push_back(dir_row(0,      1, 8192,  4, 1, 64,  1));
        dir_tab.push_back(dir_row('h2AAA, 1, 10240, 5, 0, 0,   0));
        dir_tab.push_back(dir_row('h1555, 1, 12288, 6, 0, 0,   0));
        dir_tab.push_back(dir_row('h2AAA, 1, 14336, 7, 1, 160, 1));
        dir_tab.push_back(dir_row('h1555, 1, 1,     0, 1, 192, 1));
        dir_tab.push_back(dir_row(0,      1, 2049,  1, 1, 128, 1));
        dir_tab.push_back(dir_row(1,      1, 4097,  2, 0, 0,   0));
        dir_tab.push_back(dir_row(16383,  1, 6145,  3, 1, 96,  1));
        dir_tab.push_back(dir_row(1,      0, 0, 0, 0, 0, 0));
        dir_tab.push_back(dir_row('h2000, 0, 0, 0, 0, 0, 0));
        dir_tab.push_back(dir_row('h1000, 0, 0, 0, 0, 0, 0));
        dir_tab.push_back(dir_row('h3FFE, 0, 0, 0, 0, 0, 0));
        dir_tab.push_back(dir_row('h0FFF, 0, 0, 0, 0, 0, 0));
        dir_tab.push_back(dir_row('h2AAA, 0, 0, 0, 0, 0, 0));
        dir_tab.push_back(dir_row(0,      0, 0, 0, 0, 0, 0));
        dir_tab.push_back(dir_row(16383,  0, 0, 0, 0, 0, 0));

        // Hold reset, then release it and clear the model
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        reset_alloc_model();

        // Walk the directed table
        foreach (dir_tab[i])
            push_write(dir_tab[i].lp, dir_tab[i].known, dir_tab[i].res);

        // Pause the sender until the block has answered everything
        drain_results();

        // Random writes, with one stretch of back-to-back words
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            no_gaps = (n >= 200 && n < 330);
            push_write(pick_page(), 1'b0, '0);
        end
        no_gaps = 1'b0;

        // Rewrite every page still mapped into the first block, driving up
        // its invalid count
        for (int i = 0; i < fpmw_pkg::TOTAL_PAGES; i++)
            if (map_tbl[i][fpmw_pkg::MAP_W-1]
                && map_tbl[i][fpmw_pkg::PHYS_W-1:fpmw_pkg::PG_W] == '0)
                stale_lps.push_back(fpmw_pkg::PHYS_W'(i));
        foreach (stale_lps[i])
            push_write(stale_lps[i], 1'b0, '0);

        // Drain, let the pipeline settle, then report
        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
